// ===== hw/rtl/wmis_pkg.sv =====
package wmis_pkg;

  localparam int WINDOW_DEF = 60;
  localparam int SAMPLE_W   = 32;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic                       mean_valid;
  } mean_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/windowed_mean_with_invalid_skip_core.sv =====
// Each sample passes the update, prep, bit-serial restoring divide and done states before
// its result is loaded into the output register; an empty window skips the divide steps.
// One sample is in flight at a time: the next sample is taken once the result is parked
// in the output register, and a stall on the result holds the next sample off.
// Reset (rst, synchronous, active high) clears pointer, fill count, sum, valid
// count and handshake state; the sample ring itself is not cleared.
module windowed_mean_with_invalid_skip_core #(
  parameter int WINDOW = wmis_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wmis_pkg::sample_t item,
  output logic              result_valid,
  input  logic              result_stall,
  output wmis_pkg::mean_t   result
);
  import wmis_pkg::*;

  // Derived widths: pointer, counts up to WINDOW, sum that cannot overflow.
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int ENT_W  = SAMPLE_W + 1;

  // Sample ring: {valid flag, value}, one synchronous read port.
  logic [ENT_W-1:0] ring [WINDOW];
  logic [ENT_W-1:0] rd_data;

  state_t state, state_next;

  logic        [PTR_W-1:0]    wr_ptr;
  logic        [CNT_W-1:0]    fill_count;
  logic        [CNT_W-1:0]    valid_total;
  logic signed [SUM_W-1:0]    running_sum;

  // Captured sample of the item in flight.
  logic signed [SAMPLE_W-1:0] smp;
  logic                       smp_ok;

  // Divider registers: quot shifts the dividend out and the quotient in.
  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic              mean_ok;

  // Controls from the output decoder.
  logic take_item;
  logic do_update;
  logic do_prep;
  logic do_step;
  logic do_load;

  logic                    evict;
  logic                    item_xfer;
  logic                    result_xfer;
  logic                    out_free;
  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [SUM_W-1:0] sum_upd;
  logic [CNT_W-1:0]        cnt_upd;

  assign item_xfer   = item_valid && !item_stall;
  assign result_xfer = result_valid && !result_stall;
  assign out_free    = !result_valid || !result_stall;

  // Oldest entry only leaves once the ring has wrapped; every slot is written by then.
  assign evict = (fill_count == CNT_W'(WINDOW)) && rd_data[ENT_W-1];

  always_comb begin
    sum_upd = running_sum;
    cnt_upd = valid_total;
    if (evict) begin
      sum_upd = sum_upd - SUM_W'($signed(rd_data[SAMPLE_W-1:0]));
      cnt_upd = cnt_upd - CNT_W'(1);
    end
    if (smp_ok) begin
      sum_upd = sum_upd + SUM_W'(smp);
      cnt_upd = cnt_upd + CNT_W'(1);
    end
  end

  // Magnitude fits SUM_W unsigned: |sum| never reaches 2^(SUM_W-1).
  assign sum_mag = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  // One restoring step.
  assign rem_sh = {rem, quot[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, valid_total};

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (item_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_PREP;
      ST_PREP:   state_next = (valid_total != '0) ? ST_DIVIDE : ST_DONE;
      ST_DIVIDE: if (step == STEP_W'(SUM_W - 1)) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Output decoder
  always_comb begin
    item_stall = 1'b1;
    take_item  = 1'b0;
    do_update  = 1'b0;
    do_prep    = 1'b0;
    do_step    = 1'b0;
    do_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        take_item  = item_valid;
      end
      ST_UPDATE: do_update = 1'b1;
      ST_PREP:   do_prep   = 1'b1;
      ST_DIVIDE: do_step   = 1'b1;
      ST_DONE:   do_load   = out_free;
      default:   item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring: read at the write pointer on every cycle, so the entry to be
  // overwritten is ready in the update cycle after the transfer.
  always_ff @(posedge clk) begin
    rd_data <= ring[wr_ptr];
    if (do_update) begin
      ring[wr_ptr] <= {smp_ok, smp};
    end
  end

  always_ff @(posedge clk) begin
    if (take_item && item_xfer) begin
      smp    <= item.sample;
      smp_ok <= item.sample_valid;
    end
  end

  // Window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      fill_count  <= '0;
      valid_total <= '0;
      running_sum <= '0;
    end else if (do_update) begin
      running_sum <= sum_upd;
      valid_total <= cnt_upd;
      wr_ptr      <= (wr_ptr == PTR_W'(WINDOW - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (fill_count != CNT_W'(WINDOW)) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  // Divider: magnitude divided bit by bit, sign restored at the output.
  // An empty window loads a zero quotient and skips the steps.
  always_ff @(posedge clk) begin
    if (do_prep) begin
      rem     <= '0;
      step    <= '0;
      mean_ok <= (valid_total != '0);
      if (valid_total != '0) begin
        quot <= sum_mag;
        neg  <= running_sum[SUM_W-1];
      end else begin
        quot <= '0;
        neg  <= 1'b0;
      end
    end else if (do_step) begin
      quot <= {quot[SUM_W-2:0], ge};
      rem  <= ge ? CNT_W'(rem_sh - {1'b0, valid_total}) : rem_sh[CNT_W-1:0];
      step <= step + STEP_W'(1);
    end
  end

  // Output register: holds the result while the far side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (do_load) begin
      result_valid <= 1'b1;
    end else if (result_xfer) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      result.mean       <= neg ? -$signed(quot[SAMPLE_W-1:0]) : $signed(quot[SAMPLE_W-1:0]);
      result.mean_valid <= mean_ok;
    end
  end

endmodule

// ===== tb/windowed_mean_with_invalid_skip_core_tb.sv =====
`timescale 1ns / 1ps

module windowed_mean_with_invalid_skip_core_tb;
  import wmis_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  // Drain allowance at the end, so that a stray result can still surface.
  localparam int DRAIN_CYCLES = 64;

  // All inputs start at known values; everything after time zero is driven
  // with nonblocking assignments at the rising edge.
  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  sample_t item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  mean_t   result;

  always #5 clk = ~clk;

  windowed_mean_with_invalid_skip_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // ---------------------------------------------------------------------
  // Window predictor: own copy of the sample ring, pointer, fill level,
  // running sum of valid entries and the count of those entries.
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] ring_value [WIN];
  logic                       ring_ok    [WIN];
  int unsigned                ring_wr    = 0;
  int unsigned                ring_fill  = 0;
  int unsigned                ok_count   = 0;
  longint signed              window_sum = 0;

  mean_t expected_means [$];
  int    fail_count = 0;
  bit    idle_on    = 1'b1;   // random gaps on the send side and stalls on results

  // Updates the window with one accepted sample and returns the mean it yields.
  function automatic mean_t next_mean(input sample_t s);
    mean_t m;
    if (ring_fill < WIN) begin
      ring_fill++;
    end else if (ring_ok[ring_wr]) begin
      // ring full: the oldest entry drops out, and only a valid one was summed
      window_sum -= longint'($signed(ring_value[ring_wr]));
      ok_count--;
    end
    // an invalid sample still takes its slot, it is just never summed
    ring_value[ring_wr] = s.sample;
    ring_ok[ring_wr]    = s.sample_valid;
    if (s.sample_valid) begin
      window_sum += longint'($signed(s.sample));
      ok_count++;
    end
    ring_wr = (ring_wr == WIN - 1) ? 0 : ring_wr + 1;
    m.mean_valid = (ok_count != 0);
    // signed division truncates toward zero; empty window gives a zero mean
    m.mean = m.mean_valid ? SAMPLE_W'(window_sum / longint'(ok_count)) : '0;
    return m;
  endfunction

  // Biased sample values: the extremes often, small magnitudes, then anything.
  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return $signed($urandom_range(0, 131071)) - 65536;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // One sample transfer. Called at a rising edge; returns at the edge the
  // transfer happens. item_valid is left high so back-to-back items carry
  // no bubble, and gets exactly one assignment per time step.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic ok);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{sample: v, sample_valid: ok};
    // stall is read just after the edge, so this is its value at the edge
    do @(posedge clk); while (item_stall);
    expected_means.push_back(next_mean('{sample: v, sample_valid: ok}));
  endtask

  // ---------------------------------------------------------------------
  // Result side: random burst stalls while idling is enabled.
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    mean_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mean %0d valid %0b",
                 $time, $signed(result.mean), result.mean_valid);
        fail_count++;
      end else begin
        want = expected_means.pop_front();
        if (result.mean_valid !== want.mean_valid) begin
          $display("%0t: mean_valid mismatch, expected %0b, actual %0b",
                   $time, want.mean_valid, result.mean_valid);
          fail_count++;
        end
        if (result.mean !== want.mean) begin
          $display("%0t: mean mismatch, expected %0d, actual %0d",
                   $time, $signed(want.mean), $signed(result.mean));
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Nothing valid yet: the mean must be flagged invalid and read as zero.
  task automatic test_empty_window();
    send_sample(32'sd0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
  endtask

  // Field extremes, sign handling and truncation of negative means.
  task automatic test_field_extremes();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(-32'sd1, 1'b1);
    send_sample(32'sd1, 1'b1);
    send_sample(32'sh0001_0000, 1'b1);     // 1.0 in Q16.16
    send_sample(-32'sh0000_8000, 1'b1);    // -0.5
    send_sample(-32'sd7, 1'b1);
    send_sample(32'sh5a5a_a5a5, 1'b0);     // stored, not summed
    send_sample(-32'sd3, 1'b1);
    send_sample(32'sd0, 1'b1);
    send_sample(32'sh7fff_0000, 1'b0);
    send_sample(-32'sh0001_0001, 1'b1);
    send_sample(32'sd2, 1'b1);
  endtask

  // Whole windows of extreme values, so the sum reaches its widest range and
  // eviction of extremes is exercised; the odd invalid sample mixed in.
  task automatic test_full_window_extremes();
    logic signed [SAMPLE_W-1:0] v;
    for (int w = 0; w < 4; w++) begin
      for (int i = 0; i < WIN; i++) begin
        case (w)
          0:       v = SAMPLE_MAX;
          1:       v = SAMPLE_MIN;
          2:       v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
          default: v = pick_value();
        endcase
        send_sample(v, $urandom_range(0, 15) != 0);
      end
    end
  endtask

  // A full valid window followed by a long run of missing samples: the valid
  // entries age out one by one until the mean goes invalid again.
  task automatic test_invalid_stretch();
    for (int i = 0; i < WIN + 10; i++) send_sample(pick_value(), 1'b1);
    for (int i = 0; i < WIN + 30; i++) send_sample(pick_value(), 1'b0);
    for (int i = 0; i < 40; i++) send_sample(pick_value(), $urandom_range(0, 1) != 0);
  endtask

  // Bulk random traffic in blocks with differing densities of valid samples,
  // and some blocks run without any idling.
  task automatic test_random_mix();
    int pct;
    for (int b = 0; b < 40; b++) begin
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 50;
        3:       pct = 90;
        default: pct = 100;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 29; i++)
        send_sample(pick_value(), $urandom_range(0, 99) < pct);
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_no_idle();
    idle_on = 1'b0;
    for (int i = 0; i < 200; i++) send_sample(pick_value(), $urandom_range(0, 3) != 0);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_window();
    test_field_extremes();
    test_full_window_extremes();
    test_invalid_stretch();
    test_random_mix();
    test_no_idle();
    item_valid <= 1'b0;

    while (expected_means.size() != 0) @(posedge clk);
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_means.size() == 0) begin
      $display("windowed_mean_with_invalid_skip_core_tb passed");
    end else begin
      $display("windowed_mean_with_invalid_skip_core_tb failed");
    end
    $finish;
  end

  // Watchdog: a clean run takes well under a fifth of this.
  initial begin
    #10_000_000;
    $display("windowed_mean_with_invalid_skip_core_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wmis_pkg.sv
hw/rtl/windowed_mean_with_invalid_skip_core.sv
tb/windowed_mean_with_invalid_skip_core_tb.sv
